>>> sv/pmq_pkg.sv
// pmq_pkg: shared types, codes and defaults of the priority message pool queue
// used by the channel interfaces, the controller, the datapath and the top level
package pmq_pkg;

    localparam int unsigned POOL_SLOTS_DEF    = 64;
    localparam int unsigned PAYLOAD_LIMIT_DEF = 256;
    localparam int unsigned PRIO_LEVELS_DEF   = 4;
    localparam logic [6:0]  COUNT_MAX         = 7'd127;
    localparam logic [31:0] ID_RESET          = 32'd1;

    // request codes
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_RECV = 2'd1;
    localparam logic [1:0] REQ_FREE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] dest_proc;
        logic [15:0] sender_proc;
        logic [2:0]  prio_level;
        logic [9:0]  byte_count;
        logic [63:0] payload_tag;
        logic [31:0] tick_now;
        logic [6:0]  slot_to_free;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_index;
        logic [31:0] message_id;
        logic [15:0] from_proc;
        logic [15:0] to_proc;
        logic [1:0]  out_prio;
        logic [31:0] stamp;
        logic [9:0]  out_size;
        logic [63:0] out_tag;
        logic [6:0]  queued_total;
    } t_rsp;

    // message record held per slot
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] src;
        logic [15:0] dst;
        logic [2:0]  prio;
        logic [31:0] stamp;
        logic [9:0]  size;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_LINK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic take;
        logic look;
        logic exec;
        logic link;
        logic out_valid;
    } t_cmd;

    // datapath and channels to controller
    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic need_link;
    } t_stat;

endpackage

>>> sv/pmq_req_if.sv
// pmq_req_if: request channel, valid/ready with one request per beat
// depends on pmq_pkg
interface pmq_req_if;
    logic          valid;
    logic          ready;
    pmq_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/pmq_rsp_if.sv
// pmq_rsp_if: response channel, valid/ready with one result per beat
// depends on pmq_pkg
interface pmq_rsp_if;
    logic          valid;
    logic          ready;
    pmq_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/pmq_ctrl.sv
// pmq_ctrl: operation sequencer of the message queue
// depends on pmq_pkg
module pmq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmq_pkg::t_stat i_stat,
    output pmq_pkg::t_cmd  o_cmd
);

    pmq_pkg::t_state r_state;
    pmq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmq_pkg::S_IDLE: begin
                if (i_stat.in_valid) n_state = pmq_pkg::S_LOOK;
            end
            pmq_pkg::S_LOOK: n_state = pmq_pkg::S_EXEC;
            pmq_pkg::S_EXEC: begin
                n_state = i_stat.need_link ? pmq_pkg::S_LINK : pmq_pkg::S_OUT;
            end
            pmq_pkg::S_LINK: n_state = pmq_pkg::S_OUT;
            pmq_pkg::S_OUT: begin
                if (i_stat.out_ready) n_state = pmq_pkg::S_IDLE;
            end
            default: n_state = pmq_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pmq_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.take     = i_stat.in_valid;
            end
            pmq_pkg::S_LOOK: o_cmd.look = 1'b1;
            pmq_pkg::S_EXEC: o_cmd.exec = 1'b1;
            pmq_pkg::S_LINK: o_cmd.link = 1'b1;
            pmq_pkg::S_OUT:  o_cmd.out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // the tail link write only ever follows the execute step
    a_link_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pmq_pkg::S_LINK |-> $past(r_state) == pmq_pkg::S_EXEC)
        else $error("link step without execute step");

    // a taken request always goes on to the lookup step
    a_take_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == pmq_pkg::S_LOOK)
        else $error("request taken but no lookup");

    // a result beat is held while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmq_pkg::S_OUT) && !i_stat.out_ready |=> r_state == pmq_pkg::S_OUT)
        else $error("result beat dropped under stall");

endmodule

>>> sv/pmq_dpath.sv
// pmq_dpath: slot pool, record memories, priority lists and result register
// depends on pmq_pkg
module pmq_dpath #(
    parameter int unsigned POOL_SLOTS    = pmq_pkg::POOL_SLOTS_DEF,
    parameter int unsigned PAYLOAD_LIMIT = pmq_pkg::PAYLOAD_LIMIT_DEF,
    parameter int unsigned PRIO_LEVELS   = pmq_pkg::PRIO_LEVELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pmq_pkg::t_cmd i_cmd,
    input  pmq_pkg::t_req i_req,
    output logic          o_need_link,
    output pmq_pkg::t_rsp o_rsp
);

    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int PW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;

    // link entry: top bit marks a valid successor
    logic [SW:0]          mem_link [POOL_SLOTS];
    pmq_pkg::t_rec        mem_rec  [POOL_SLOTS];
    logic [63:0]          mem_tag  [POOL_SLOTS];

    logic [POOL_SLOTS-1:0] r_busy;
    logic [SW-1:0]         r_free_idx;
    logic                  r_full;
    logic [SW-1:0]         r_head [PRIO_LEVELS];
    logic                  r_head_ok [PRIO_LEVELS];
    logic [SW-1:0]         r_tail [PRIO_LEVELS];
    logic                  r_tail_ok [PRIO_LEVELS];
    logic [31:0]           r_id;
    logic [6:0]            r_count;
    logic [6:0]            n_count;
    pmq_pkg::t_req         r_req;
    logic [PW-1:0]         r_pick;
    logic                  r_pick_ok;
    logic [SW:0]           r_rd_link;
    pmq_pkg::t_rec         r_rd_rec;
    logic [63:0]           r_rd_tag;
    logic [SW-1:0]         r_link_addr;
    logic [SW-1:0]         r_link_slot;
    pmq_pkg::t_rsp         r_rsp;
    pmq_pkg::t_rsp         n_rsp;

    logic [PW-1:0] pick;
    logic          pick_ok;
    logic [PW-1:0] sp;
    logic          args_ok;
    logic          send_go;
    logic          recv_go;
    logic          free_go;
    logic [SW-1:0] free_slot;
    logic          wr_link;
    logic [SW-1:0] wr_link_addr;
    logic [SW:0]   wr_link_data;

    // decode of the held request
    always_comb begin
        sp        = PW'(r_req.prio_level);
        args_ok   = (r_req.byte_count != 10'd0)
                  && (32'(r_req.byte_count) <= PAYLOAD_LIMIT)
                  && (32'(r_req.prio_level) < PRIO_LEVELS);
        send_go   = i_cmd.exec && (r_req.req_type == pmq_pkg::REQ_SEND) && args_ok && !r_full;
        recv_go   = i_cmd.exec && (r_req.req_type == pmq_pkg::REQ_RECV) && r_pick_ok;
        free_slot = SW'(r_req.slot_to_free);
        free_go   = i_cmd.exec && (r_req.req_type == pmq_pkg::REQ_FREE)
                  && (32'(r_req.slot_to_free) < POOL_SLOTS);
    end

    assign o_need_link = send_go && r_head_ok[sp] && r_tail_ok[sp];

    // highest non-empty list
    always_comb begin
        pick    = '0;
        pick_ok = 1'b0;
        for (int p = 0; p < PRIO_LEVELS; p++) begin
            if (r_head_ok[p]) begin
                pick    = PW'(p);
                pick_ok = 1'b1;
            end
        end
    end

    // lowest free slot, refreshed every cycle from the busy marks
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] idx;
        logic          full;
        idx  = '0;
        full = 1'b1;
        for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                idx  = SW'(s);
                full = 1'b0;
            end
        end
        r_free_idx <= idx;
        r_full     <= full;
    end

    // request hold and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_req <= i_req;
        if (i_cmd.look) begin
            r_pick    <= pick;
            r_pick_ok <= pick_ok;
        end
        if (send_go) begin
            r_link_addr <= r_tail[sp];
            r_link_slot <= r_free_idx;
        end
    end

    // record and tag memories
    always_ff @(posedge i_clk) begin
        if (send_go) begin
            mem_rec[r_free_idx] <= '{id: r_id, src: r_req.sender_proc,
                                     dst: r_req.dest_proc, prio: r_req.prio_level,
                                     stamp: r_req.tick_now, size: r_req.byte_count};
            mem_tag[r_free_idx] <= r_req.payload_tag;
        end
        if (i_cmd.look) begin
            r_rd_rec <= mem_rec[r_head[pick]];
            r_rd_tag <= mem_tag[r_head[pick]];
        end
    end

    // link memory write select
    always_comb begin
        wr_link      = 1'b0;
        wr_link_addr = r_free_idx;
        wr_link_data = '0;
        if (i_cmd.link) begin
            wr_link      = 1'b1;
            wr_link_addr = r_link_addr;
            wr_link_data = {1'b1, r_link_slot};
        end else if (send_go) begin
            wr_link      = 1'b1;
            wr_link_addr = r_free_idx;
        end else if (recv_go) begin
            wr_link      = 1'b1;
            wr_link_addr = r_head[r_pick];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (wr_link) mem_link[wr_link_addr] <= wr_link_data;
        if (i_cmd.look) r_rd_link <= mem_link[r_head[pick]];
    end

    // busy marks, list pointers, id and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_id    <= pmq_pkg::ID_RESET;
            r_count <= '0;
            for (int p = 0; p < PRIO_LEVELS; p++) begin
                r_head_ok[p] <= 1'b0;
                r_tail_ok[p] <= 1'b0;
            end
        end else begin
            r_count <= n_count;
            if (send_go) begin
                r_busy[r_free_idx] <= 1'b1;
                r_id               <= r_id + 32'd1;
                r_tail[sp]         <= r_free_idx;
                r_tail_ok[sp]      <= 1'b1;
                if (!(r_head_ok[sp] && r_tail_ok[sp])) begin
                    r_head[sp]    <= r_free_idx;
                    r_head_ok[sp] <= 1'b1;
                end
            end
            if (recv_go) begin
                r_head[r_pick]    <= r_rd_link[SW-1:0];
                r_head_ok[r_pick] <= r_rd_link[SW];
            end
            if (free_go) r_busy[free_slot] <= 1'b0;
        end
    end

    // count after the operation and result fields
    always_comb begin
        n_count = r_count;
        if (send_go && r_count != pmq_pkg::COUNT_MAX) n_count = r_count + 7'd1;
        if (recv_go && r_count != 7'd0) n_count = r_count - 7'd1;

        n_rsp              = '0;
        n_rsp.status       = pmq_pkg::ST_BAD;
        n_rsp.queued_total = n_count;
        case (r_req.req_type)
            pmq_pkg::REQ_SEND: begin
                if (!args_ok) begin
                    n_rsp.status = pmq_pkg::ST_BAD;
                end else if (r_full) begin
                    n_rsp.status = pmq_pkg::ST_FULL;
                end else begin
                    n_rsp.status     = pmq_pkg::ST_OK;
                    n_rsp.slot_index = 6'(r_free_idx);
                    n_rsp.message_id = r_id;
                end
            end
            pmq_pkg::REQ_RECV: begin
                if (r_pick_ok) begin
                    n_rsp.status     = pmq_pkg::ST_OK;
                    n_rsp.slot_index = 6'(r_head[r_pick]);
                    n_rsp.message_id = r_rd_rec.id;
                    n_rsp.from_proc  = r_rd_rec.src;
                    n_rsp.to_proc    = r_rd_rec.dst;
                    n_rsp.out_prio   = r_rd_rec.prio[1:0];
                    n_rsp.stamp      = r_rd_rec.stamp;
                    n_rsp.out_size   = r_rd_rec.size;
                    n_rsp.out_tag    = r_rd_tag;
                end else begin
                    n_rsp.status = pmq_pkg::ST_EMPTY;
                end
            end
            pmq_pkg::REQ_FREE: begin
                if (32'(r_req.slot_to_free) < POOL_SLOTS) begin
                    n_rsp.status     = pmq_pkg::ST_OK;
                    n_rsp.slot_index = 6'(r_req.slot_to_free);
                end
            end
            default: n_rsp.status = pmq_pkg::ST_BAD;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

    // a granted send leaves its slot marked busy
    a_send_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_go |=> r_busy[$past(r_free_idx)])
        else $error("sent slot not marked busy");

    // a pop lowers the count by one unless already zero
    a_recv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        recv_go |=> (r_count + 7'd1 == $past(r_count)) || ($past(r_count) == 7'd0))
        else $error("count not lowered by pop");

    // a granted send advances the message id
    a_send_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_go |=> r_id == $past(r_id) + 32'd1)
        else $error("message id not advanced");

endmodule

>>> sv/priority_message_pool_queue.sv
// priority_message_pool_queue: message queue over a slot pool with priority lists
// depends on pmq_pkg, pmq_req_if, pmq_rsp_if, pmq_ctrl and pmq_dpath
//
// Usage: each request beat on i_req is a send, a receive or a slot free. A send
// checks size and priority, takes the lowest free slot, stamps the next message
// id and appends the message to the tail of its priority list. A receive pops
// the head of the highest non-empty list. A free only clears the slot's busy mark.
// Exactly one result beat leaves on o_rsp for every request beat.
// Sequence: a taken request passes through the lookup, execute and output states,
// with a link state after execute for a send that appends to a non-empty list (a
// write of the old tail's link, as the link memory has a single write port). One
// request is in flight at a time, so a new request is taken the cycle after the
// result is taken.
// Reset: all slots free, all lists empty, message id 1, count 0; record memories
// are not cleared, as every slot is written by a send before it can be read.
// Stall: while o_rsp.ready is low the result holds and i_req.ready stays low.
module priority_message_pool_queue #(
    parameter int unsigned POOL_SLOTS    = pmq_pkg::POOL_SLOTS_DEF,
    parameter int unsigned PAYLOAD_LIMIT = pmq_pkg::PAYLOAD_LIMIT_DEF,
    parameter int unsigned PRIO_LEVELS   = pmq_pkg::PRIO_LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmq_req_if.sink   i_req,
    pmq_rsp_if.source o_rsp
);

    pmq_pkg::t_cmd  cmd;
    pmq_pkg::t_stat stat;
    logic           need_link;

    // handshake status to the controller
    always_comb begin
        stat.in_valid  = i_req.valid;
        stat.out_ready = o_rsp.ready;
        stat.need_link = need_link;
    end

    assign i_req.ready = cmd.in_ready;
    assign o_rsp.valid = cmd.out_valid;

    pmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pmq_dpath #(
        .POOL_SLOTS    (POOL_SLOTS),
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT),
        .PRIO_LEVELS   (PRIO_LEVELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.payload),
        .o_need_link (need_link),
        .o_rsp       (o_rsp.payload)
    );

endmodule
